// ===== design/pvca_pkg.sv =====
// Package for the phase voltage/current alarm block.
// Holds payload structs, alarm codes and configuration register indexes.
// No dependencies.
package pvca_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_OVER_VOLT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UNDER_VOLT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOSS_VOLT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CURR_SET   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_THREE_PH   = 3'd5;

	localparam logic [15:0] OVER_VOLT_RST  = 16'd2640;
	localparam logic [15:0] UNDER_VOLT_RST = 16'd1870;
	localparam logic [15:0] LOSS_VOLT_RST  = 16'd500;
	localparam logic [15:0] DEBOUNCE_RST   = 16'd3000;

	localparam logic [9:0]  CURR_MIN_SETTING = 10'd16;
	localparam logic [13:0] CURR_FACTOR      = 14'd11;
	localparam logic [13:0] CURR_DEFAULT_TH  = 14'd180;

	// output event kind
	localparam logic [1:0] KIND_OVER_VOLT  = 2'd0;
	localparam logic [1:0] KIND_UNDER_VOLT = 2'd1;
	localparam logic [1:0] KIND_LOSS       = 2'd2;
	localparam logic [1:0] KIND_OVER_CURR  = 2'd3;

	// output event level
	localparam logic [1:0] LEVEL_CLEARED = 2'd0;
	localparam logic [1:0] LEVEL_WARN    = 2'd1;
	localparam logic [1:0] LEVEL_FAULT   = 2'd2;

	typedef enum logic [1:0] {
		VST_NONE  = 2'd0,
		VST_UNDER = 2'd1,
		VST_OVER  = 2'd2,
		VST_LOSS  = 2'd3
	} volt_st_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic [15:0] voltage;
		logic [15:0] current;
		logic [7:0]  elapsed;
	} meas_t;

	typedef struct packed {
		logic [1:0]  alarm_kind;
		logic [1:0]  alarm_phase;
		logic [1:0]  alarm_level;
		logic [15:0] over_volt_total;
		logic [15:0] under_volt_total;
		logic [15:0] over_curr_total;
		logic        last_event;
	} alarm_t;

endpackage

// ===== design/phase_voltage_current_alarm.sv =====
// Phase voltage/current alarm, top level; uses pvca_pkg. Each measurement
// (phase, voltage, current, elapsed time) is classed into a voltage band and
// checked against the current threshold; debounced raise and immediate clear
// events come out one per transaction with the saturating alarm totals, and
// last_event marks the final event of a measurement. A measurement is held
// in the input register, and its events go from there into the event buffer,
// whose head is presented; state is updated as it leaves the input register,
// so a new measurement can be taken every cycle while the event buffer has
// room: the input register moves on only when the buffer is empty or holds
// one event that is being taken. The buffer drains one event per cycle while
// out_ready is high. Configuration writes are taken every cycle.
module phase_voltage_current_alarm #(
	parameter int NUM_PHASES = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  pvca_pkg::meas_t               in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pvca_pkg::alarm_t              out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pvca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);
	import pvca_pkg::*;

	localparam int PW = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;

	// configuration
	logic [15:0] ovl_q, uvl_q, lvl_q, deb_q;
	logic [9:0]  cset_q;
	logic        three_ph_q;

	// per-phase state and totals
	volt_st_t    vst_q  [NUM_PHASES];
	logic [15:0] vtmr_q [NUM_PHASES];
	logic        cst_q  [NUM_PHASES];
	logic [15:0] ctmr_q [NUM_PHASES];
	logic [15:0] ov_cnt_q, uv_cnt_q, oc_cnt_q;

	// input register
	logic  s1_valid;
	meas_t s1_q;

	// event buffer, head at index 0
	alarm_t     ev_q [3];
	logic [1:0] n_q;

	logic       buf_free, s1_move, ph_ok;
	logic [PW-1:0] p;

	// next state from the combinational pass
	volt_st_t    nv_st;
	logic [15:0] nv_tmr, nc_tmr, ov_n, uv_n, oc_n;
	logic        nc_st;
	alarm_t      pk [3];
	logic [1:0]  new_n;

	function automatic logic [1:0] kind_of(volt_st_t st);
		logic [1:0] k;
		case (st)
			VST_OVER:  k = KIND_OVER_VOLT;
			VST_UNDER: k = KIND_UNDER_VOLT;
			default:   k = KIND_LOSS;
		endcase
		return k;
	endfunction

	function automatic logic [15:0] sat_add(logic [15:0] a, logic [7:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {9'd0, b};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	function automatic logic [15:0] sat_inc(logic [15:0] a);
		return (a == 16'hFFFF) ? a : a + 16'd1;
	endfunction

	assign cfg_ready = 1'b1;
	assign buf_free  = (n_q == 2'd0) || (n_q == 2'd1 && out_ready);
	assign s1_move   = s1_valid && buf_free;
	assign in_ready  = !s1_valid || buf_free;
	assign out_valid = (n_q != 2'd0);
	assign out_data  = ev_q[0];

	assign p     = s1_q.phase[PW-1:0];
	assign ph_ok = (32'(s1_q.phase) < NUM_PHASES) && (three_ph_q || s1_q.phase == 2'd0);

	always_comb begin
		volt_st_t    want, cur;
		logic [15:0] vt_add, ct_add;
		logic [13:0] th;
		logic        clr_v, rse_v, c_ev;
		alarm_t      evs [3];
		logic        ok  [3];
		logic [1:0]  n;

		cur   = vst_q[p];
		want  = VST_NONE;
		if (s1_q.voltage >= ovl_q)
			want = VST_OVER;
		else if (s1_q.voltage <= uvl_q && s1_q.voltage > lvl_q)
			want = VST_UNDER;
		else if (s1_q.voltage <= lvl_q)
			want = VST_LOSS;

		vt_add = sat_add(vtmr_q[p], s1_q.elapsed);
		nv_st  = cur;
		nv_tmr = vtmr_q[p];
		clr_v  = 1'b0;
		rse_v  = 1'b0;
		ov_n   = ov_cnt_q;
		uv_n   = uv_cnt_q;
		if (want == VST_NONE) begin
			// normal band: clear at once, timer kept when an alarm was active
			if (cur != VST_NONE) begin
				nv_st = VST_NONE;
				clr_v = 1'b1;
			end else begin
				nv_tmr = 16'd0;
			end
		end else if (cur != want) begin
			if (vt_add < deb_q) begin
				nv_tmr = vt_add;
			end else begin
				nv_tmr = 16'd0;
				clr_v  = (cur != VST_NONE);
				nv_st  = want;
				rse_v  = 1'b1;
				if (want == VST_OVER)
					ov_n = sat_inc(ov_cnt_q);
				else if (want == VST_UNDER)
					uv_n = sat_inc(uv_cnt_q);
			end
		end

		th     = (cset_q > CURR_MIN_SETTING) ? {4'd0, cset_q} * CURR_FACTOR : CURR_DEFAULT_TH;
		ct_add = sat_add(ctmr_q[p], s1_q.elapsed);
		nc_st  = cst_q[p];
		nc_tmr = ctmr_q[p];
		oc_n   = oc_cnt_q;
		c_ev   = 1'b0;
		if (s1_q.current >= {2'd0, th}) begin
			if (!cst_q[p]) begin
				if (ct_add < deb_q) begin
					nc_tmr = ct_add;
				end else begin
					nc_tmr = 16'd0;
					nc_st  = 1'b1;
					oc_n   = sat_inc(oc_cnt_q);
					c_ev   = 1'b1;
				end
			end
		end else begin
			nc_tmr = 16'd0;
			if (cst_q[p]) begin
				nc_st = 1'b0;
				c_ev  = 1'b1;
			end
		end

		// clear of the old voltage alarm carries the totals before this raise
		evs[0] = '{alarm_kind: kind_of(cur), alarm_phase: s1_q.phase,
			alarm_level: LEVEL_CLEARED, over_volt_total: ov_cnt_q,
			under_volt_total: uv_cnt_q, over_curr_total: oc_cnt_q, last_event: 1'b0};
		evs[1] = '{alarm_kind: kind_of(want), alarm_phase: s1_q.phase,
			alarm_level: (want == VST_LOSS) ? LEVEL_WARN : LEVEL_FAULT,
			over_volt_total: ov_n, under_volt_total: uv_n,
			over_curr_total: oc_cnt_q, last_event: 1'b0};
		evs[2] = '{alarm_kind: KIND_OVER_CURR, alarm_phase: s1_q.phase,
			alarm_level: nc_st ? LEVEL_FAULT : LEVEL_CLEARED,
			over_volt_total: ov_n, under_volt_total: uv_n,
			over_curr_total: oc_n, last_event: 1'b0};
		ok[0] = clr_v;
		ok[1] = rse_v;
		ok[2] = c_ev;

		for (int i = 0; i < 3; i++)
			pk[i] = evs[2];
		n = 2'd0;
		for (int i = 0; i < 3; i++) begin
			if (ok[i]) begin
				pk[n] = evs[i];
				n     = n + 2'd1;
			end
		end
		if (n != 2'd0)
			pk[n - 2'd1].last_event = 1'b1;
		new_n = ph_ok ? n : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovl_q      <= OVER_VOLT_RST;
			uvl_q      <= UNDER_VOLT_RST;
			lvl_q      <= LOSS_VOLT_RST;
			deb_q      <= DEBOUNCE_RST;
			cset_q     <= '0;
			three_ph_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_OVER_VOLT:  ovl_q      <= cfg_data;
				REG_UNDER_VOLT: uvl_q      <= cfg_data;
				REG_LOSS_VOLT:  lvl_q      <= cfg_data;
				REG_DEBOUNCE:   deb_q      <= cfg_data;
				REG_CURR_SET:   cset_q     <= cfg_data[9:0];
				REG_THREE_PH:   three_ph_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PHASES; i++) begin
				vst_q[i]  <= VST_NONE;
				vtmr_q[i] <= '0;
				cst_q[i]  <= 1'b0;
				ctmr_q[i] <= '0;
			end
			ov_cnt_q <= '0;
			uv_cnt_q <= '0;
			oc_cnt_q <= '0;
		end else if (s1_move && ph_ok) begin
			vst_q[p]  <= nv_st;
			vtmr_q[p] <= nv_tmr;
			cst_q[p]  <= nc_st;
			ctmr_q[p] <= nc_tmr;
			ov_cnt_q  <= ov_n;
			uv_cnt_q  <= uv_n;
			oc_cnt_q  <= oc_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else if (in_ready)
			s1_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			s1_q <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			n_q <= 2'd0;
		else if (s1_move)
			n_q <= new_n;
		else if (out_valid && out_ready)
			n_q <= n_q - 2'd1;
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			ev_q <= pk;
		end else if (out_valid && out_ready) begin
			ev_q[0] <= ev_q[1];
			ev_q[1] <= ev_q[2];
		end
	end

`ifndef SYNTHESIS
	a_last_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && n_q == 2'd1 |-> out_data.last_event)
		else $error("single buffered event not marked last");

	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_event |-> n_q > 2'd1)
		else $error("non-final event with nothing behind it");

	a_curr_no_warn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.alarm_kind == KIND_OVER_CURR |->
		out_data.alarm_level != LEVEL_WARN)
		else $error("over-current event at warning level");

	a_ov_mono: assert property (@(posedge clk) disable iff (!arst_n)
		ov_cnt_q >= $past(ov_cnt_q) && oc_cnt_q >= $past(oc_cnt_q))
		else $error("alarm total decreased");

	a_no_update_without_move: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_move |=> $stable(ov_cnt_q) && $stable(uv_cnt_q) && $stable(oc_cnt_q))
		else $error("totals changed with no transaction retired");
`endif

endmodule
